>>> rtl/core/jbec_pkg.sv
// ----------------------------------------------------------------------------
// jbec_pkg: shared types and Huffman code ROMs
// Holds the types passed between stages and the Huffman tables, standard
// but for DC luma, built into canonical code ROMs at elaboration.
// ----------------------------------------------------------------------------
package jbec_pkg;

  localparam logic [7:0] ZRL_SYM    = 8'hF0;
  localparam logic [7:0] EOB_SYM    = 8'h00;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [5:0] LAST_POS   = 6'd63;

  typedef logic [7:0]  counts_t [16];
  typedef logic [7:0]  vals_t [162];
  // One ROM word is {length[4:0], code[15:0]}.
  typedef logic [20:0] rom_t [256];

  // Bits of one item, left aligned, with their count.
  typedef struct packed {
    logic [63:0] bits;
    logic [6:0]  len;
    logic        flush;
  } chunk_t;

  // Whole bytes produced by one item, first byte in the top bits.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
  } packet_t;

  function automatic rom_t build_rom(counts_t counts, vals_t vals, int nvals);
    rom_t r;
    int   code;
    int   pos;
    code = 0;
    pos  = 0;
    for (int i = 0; i < 256; i++) r[i] = '0;
    for (int k = 1; k <= 16; k++) begin
      for (int i = 0; i < int'(counts[k-1]); i++) begin
        if (pos < nvals) r[vals[pos]] = {5'(k), 16'(code)};
        code++;
        pos++;
      end
      code = code << 1;
    end
    return r;
  endfunction

  localparam rom_t DC_LUMA = build_rom(
    '{8'd0, 8'd0, 8'd7, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{0: 8'd4, 1: 8'd5, 2: 8'd3, 3: 8'd2, 4: 8'd6, 5: 8'd1, 6: 8'd0, 7: 8'd7,
      8: 8'd8, 9: 8'd9, 10: 8'd10, 11: 8'd11, default: 8'd0},
    12);

  localparam rom_t DC_CHROMA = build_rom(
    '{8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{0: 8'd0, 1: 8'd1, 2: 8'd2, 3: 8'd3, 4: 8'd4, 5: 8'd5, 6: 8'd6, 7: 8'd7,
      8: 8'd8, 9: 8'd9, 10: 8'd10, 11: 8'd11, default: 8'd0},
    12);

  localparam rom_t AC_LUMA = build_rom(
    '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
      8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d},
    '{8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12,
      8'h21, 8'h31, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'h07,
      8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
      8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0,
      8'h24, 8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16,
      8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
      8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
      8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
      8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
      8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
      8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
      8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
      8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
      8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
      8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5,
      8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4,
      8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
      8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea,
      8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
      8'hf9, 8'hfa},
    162);

  localparam rom_t AC_CHROMA = build_rom(
    '{8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
      8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77},
    '{8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21,
      8'h31, 8'h06, 8'h12, 8'h41, 8'h51, 8'h07, 8'h61, 8'h71,
      8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
      8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0,
      8'h15, 8'h62, 8'h72, 8'hd1, 8'h0a, 8'h16, 8'h24, 8'h34,
      8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
      8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
      8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
      8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
      8'h69, 8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
      8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
      8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5,
      8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
      8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3,
      8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2,
      8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
      8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9,
      8'hea, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
      8'hf9, 8'hfa},
    162);

endpackage

>>> rtl/core/jpeg_baseline_entropy_coder.sv
// ----------------------------------------------------------------------------
// jpeg_baseline_entropy_coder: baseline Huffman entropy coder
// Codes quantized zigzag coefficients into a byte-stuffed entropy stream.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid / in_stall) carries one beat per
// coefficient: kind, component and coefficient. Send 64 beats per block in
// zigzag order; the component is taken on the first beat of each block. A
// beat with kind set flushes the scan: the last partial byte is padded with
// ones, and the predictors and block position are cleared.
// The output channel (out_valid / out_stall) carries one byte per beat;
// last_of_run marks the final byte caused by one input beat, stuffed 0x00
// included. Beats that produce no byte (most zero coefficients) leave no
// trace on the output.
// Throughput is one input beat per cycle while in_stall is low: coding takes
// one pass through the symbol coder and one through the bit packer. Bytes
// leave at one per cycle while out_stall is low, from a small packet queue,
// so a long burst of bytes from one beat slows the input only once the queue
// fills.
// in_stall rises when the queue plus the items in flight would exceed the
// queue depth, so a stalled receiver backs up into the input. After reset
// the valid flags, pointers and coder state are clear and beats are accepted at once.
// ----------------------------------------------------------------------------
module jpeg_baseline_entropy_coder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [1:0]  component,
  input  logic [10:0] coefficient,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);
  import jbec_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Input register.
  logic        a_valid;
  logic        a_kind;
  logic [1:0]  a_component;
  logic [10:0] a_coefficient;

  // Coded bits register.
  chunk_t      chunk;
  logic        b_valid;
  chunk_t      b_chunk;

  // Packer state: pending bits are kept left aligned in one byte.
  logic [7:0]  pend;
  logic [2:0]  cnt;
  logic [7:0]  pend_next;
  logic [2:0]  cnt_next;
  logic [71:0] merged;
  logic [6:0]  total;
  packet_t     packet;
  logic        push;

  // Packet queue.
  packet_t     queue [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] qcount;
  logic [CW:0]   reserved;
  packet_t     head;

  // Output side.
  logic [2:0]  bidx;
  logic        stuff_pending;
  logic        stuff_last;
  logic        load;
  logic [7:0]  head_byte;
  logic        head_end;
  logic        pop;

  // Every item in flight can leave at most one packet, so the input only
  // proceeds while the queue has a slot for each of them.
  assign reserved = (CW + 1)'(qcount) + (CW + 1)'(a_valid) + (CW + 1)'(b_valid);
  assign in_stall = (reserved >= (CW + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid && !in_stall;
    end
    if (in_valid && !in_stall) begin
      a_kind        <= kind;
      a_component   <= component;
      a_coefficient <= coefficient;
    end
  end

  jbec_symbol_coder u_coder (
    .clk         (clk),
    .rst         (rst),
    .fire        (a_valid),
    .kind        (a_kind),
    .component   (a_component),
    .coefficient (a_coefficient),
    .chunk       (chunk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_chunk <= chunk;
  end

  // The new bits go behind the pending ones; whole bytes go to the queue
  // and the remainder stays pending.
  always_comb begin
    merged    = {pend, 64'b0} | ({b_chunk.bits, 8'b0} >> cnt);
    total     = 7'(cnt) + b_chunk.len;
    pend_next = '0;
    for (int i = 0; i <= 8; i++) begin
      if (total[6:3] == 4'(i)) pend_next = merged[71 - 8*i -: 8];
    end
    cnt_next     = total[2:0];
    packet.bytes = merged[71:8];
    packet.count = total[6:3];
    if (b_chunk.flush) begin
      pend_next    = '0;
      cnt_next     = '0;
      packet.bytes = {pend | (8'hFF >> cnt), 56'b0};
      packet.count = (cnt != '0) ? 4'd1 : 4'd0;
    end
    push = b_valid && (packet.count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt  <= '0;
    end else if (b_valid) begin
      pend <= pend_next;
      cnt  <= cnt_next;
    end
  end

  // Byte output: one byte per cycle while out_stall is low, from the queue head,
  // with a zero byte inserted after every 0xFF.
  assign load = !out_valid || !out_stall;

  always_comb begin
    head      = queue[rd_ptr];
    head_byte = head.bytes[63 - 8*bidx -: 8];
    head_end  = ({1'b0, bidx} + 4'd1 == head.count);
    pop       = load && !stuff_pending && (qcount != '0) && head_end;
  end

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= packet;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcount <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      qcount <= qcount + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      stuff_pending <= 1'b0;
      bidx          <= '0;
    end else if (load) begin
      if (stuff_pending) begin
        out_valid     <= 1'b1;
        out_byte      <= 8'h00;
        last_of_run   <= stuff_last;
        stuff_pending <= 1'b0;
      end else if (qcount != '0) begin
        out_valid <= 1'b1;
        out_byte  <= head_byte;
        if (head_byte == STUFF_BYTE) begin
          stuff_pending <= 1'b1;
          stuff_last    <= head_end;
          last_of_run   <= 1'b0;
        end else begin
          last_of_run <= head_end;
        end
        bidx <= head_end ? 3'd0 : bidx + 3'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/jbec_symbol_coder.sv
// ----------------------------------------------------------------------------
// jbec_symbol_coder: per-coefficient Huffman coding
// Tracks block position, component, DC predictors and the zero run, and
// turns one registered coefficient into a left-aligned string of code bits.
// ----------------------------------------------------------------------------
module jbec_symbol_coder (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              kind,
  input  logic [1:0]        component,
  input  logic [10:0]       coefficient,
  output jbec_pkg::chunk_t  chunk
);
  import jbec_pkg::*;

  logic [5:0]  position;
  logic [1:0]  block_component;
  logic [10:0] pred [3];
  logic [5:0]  zero_run;

  logic        is_dc;
  logic        coef_zero;
  logic [1:0]  comp_eff;
  logic [1:0]  comp_sel;
  logic        chroma;
  logic [11:0] diff;
  logic [10:0] coef_ac;
  logic [11:0] v;
  logic [10:0] mag;
  logic [3:0]  cat;
  logic [11:0] vb;
  logic [11:0] vb_masked;
  logic [7:0]  ac_sym;
  logic [20:0] dc_entry;
  logic [20:0] ac_entry;
  logic [20:0] zrl_entry;
  logic        use_code;
  logic        use_val;
  logic [1:0]  nzrl;
  logic [20:0] code_entry;
  logic [4:0]  clen;
  logic [3:0]  vlen;
  logic [26:0] rbits;
  logic [5:0]  l1;
  logic [15:0] zc;
  logic [4:0]  zl;
  logic [32:0] zbits;
  logic [6:0]  zlen;
  logic [63:0] fbits;
  logic [6:0]  nl;

  always_comb begin
    is_dc     = (position == '0);
    coef_zero = (coefficient == '0);
    comp_eff  = (component == 2'd3) ? 2'd2 : component;
    comp_sel  = is_dc ? comp_eff : block_component;
    chroma    = (comp_sel != 2'd0);

    diff    = {coefficient[10], coefficient} - {pred[comp_eff][10], pred[comp_eff]};
    // The most negative AC value has no category of its own; it is coded as one above.
    coef_ac = (coefficient == 11'h400) ? 11'h401 : coefficient;
    v       = is_dc ? diff : {coef_ac[10], coef_ac};
    mag     = v[11] ? 11'(-v) : v[10:0];
    cat     = '0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) cat = 4'(i + 1);
    end
    vb        = v[11] ? (v - 12'd1) : v;
    vb_masked = vb & ((12'd1 << cat) - 12'd1);

    ac_sym    = coef_zero ? EOB_SYM : {zero_run[3:0], cat};
    dc_entry  = chroma ? DC_CHROMA[{4'b0, cat}] : DC_LUMA[{4'b0, cat}];
    ac_entry  = chroma ? AC_CHROMA[ac_sym] : AC_LUMA[ac_sym];
    zrl_entry = chroma ? AC_CHROMA[ZRL_SYM] : AC_LUMA[ZRL_SYM];

    use_code = 1'b0;
    use_val  = 1'b0;
    nzrl     = '0;
    if (!kind) begin
      if (is_dc) begin
        use_code = 1'b1;
        use_val  = 1'b1;
      end else if (!coef_zero) begin
        use_code = 1'b1;
        use_val  = 1'b1;
        nzrl     = zero_run[5:4];
      end else if (position == LAST_POS) begin
        use_code = 1'b1;
      end
    end

    code_entry = is_dc ? dc_entry : ac_entry;
    clen  = use_code ? code_entry[20:16] : 5'd0;
    vlen  = use_val ? cat : 4'd0;
    rbits = use_code ? ((27'(code_entry[15:0]) << vlen) | 27'(vb_masked)) : 27'd0;
    l1    = 6'(clen) + 6'(vlen);

    zc = zrl_entry[15:0];
    zl = zrl_entry[20:16];
    case (nzrl)
      2'd0:    zbits = '0;
      2'd1:    zbits = 33'(zc);
      2'd2:    zbits = (33'(zc) << zl) | 33'(zc);
      2'd3:    zbits = (33'(zc) << {zl, 1'b0}) | (33'(zc) << zl) | 33'(zc);
      default: zbits = '0;
    endcase
    zlen  = 7'(nzrl) * 7'(zl);
    fbits = (64'(zbits) << l1) | 64'(rbits);
    nl    = zlen + 7'(l1);

    chunk.bits  = fbits << (7'd64 - nl);
    chunk.len   = nl;
    chunk.flush = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      block_component <= '0;
      pred[0]         <= '0;
      pred[1]         <= '0;
      pred[2]         <= '0;
      zero_run        <= '0;
    end else if (fire) begin
      if (kind) begin
        pred[0]  <= '0;
        pred[1]  <= '0;
        pred[2]  <= '0;
        position <= '0;
        zero_run <= '0;
      end else if (is_dc) begin
        block_component <= comp_eff;
        pred[comp_eff]  <= coefficient;
        zero_run        <= '0;
        position        <= 6'd1;
      end else begin
        if (position == LAST_POS) begin
          position <= '0;
          zero_run <= '0;
        end else begin
          position <= position + 6'd1;
          zero_run <= coef_zero ? (zero_run + 6'd1) : 6'd0;
        end
      end
    end
  end

endmodule

>>> verif/jpeg_baseline_entropy_coder_test.sv
// ----------------------------------------------------------------------------
// jpeg_baseline_entropy_coder_test: self-checking bench for the entropy coder
// Feeds zigzag coefficient blocks and flush beats into the coder. Every
// accepted input beat is run through a bit-exact byte stream predictor, and
// each output byte is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module jpeg_baseline_entropy_coder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Values of the kind field.
  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Table selectors of the predictor.
  localparam int TBL_DC_LUMA   = 0;
  localparam int TBL_DC_CHROMA = 1;
  localparam int TBL_AC_LUMA   = 2;
  localparam int TBL_AC_CHROMA = 3;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } coded_byte_t;

  // The predictor keeps its own copy of the coder state. It turns every
  // accepted beat into the bytes it must produce and checks output bytes
  // against them in order.
  class stream_predictor;
    int          rom_code[4][256];
    int          rom_len[4][256];
    int          blk_pos;
    int          blk_comp;
    int          dc_last[3];
    int          zeros;
    int unsigned acc;
    int          acc_bits;
    coded_byte_t expected_bytes[$];
    int          errors;

    function new();
      byte unsigned dcl_n[$];
      byte unsigned dcl_v[$];
      byte unsigned dcc_n[$];
      byte unsigned dcc_v[$];
      byte unsigned acl_n[$];
      byte unsigned acl_v[$];
      byte unsigned acc_n[$];
      byte unsigned acc_v[$];
      dcl_n = '{0, 0, 7, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};
      dcl_v = '{4, 5, 3, 2, 6, 1, 0, 7, 8, 9, 10, 11};
      dcc_n = '{0, 3, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0};
      dcc_v = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11};
      acl_n = '{0, 2, 1, 3, 3, 2, 4, 3, 5, 5, 4, 4, 0, 0, 1, 8'h7d};
      acl_v = '{
        8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41,
        8'h06, 8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91,
        8'ha1, 8'h08, 8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24,
        8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53,
        8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66,
        8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
        8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h92, 8'h93,
        8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5,
        8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7,
        8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9,
        8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1,
        8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf1, 8'hf2,
        8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa};
      acc_n = '{0, 2, 1, 2, 4, 4, 3, 4, 7, 5, 4, 4, 0, 1, 2, 8'h77};
      acc_v = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21, 8'h31, 8'h06, 8'h12,
        8'h41, 8'h51, 8'h07, 8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14,
        8'h42, 8'h91, 8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0, 8'h15,
        8'h62, 8'h72, 8'hd1, 8'h0a, 8'h16, 8'h24, 8'h34, 8'he1, 8'h25, 8'hf1, 8'h17,
        8'h18, 8'h19, 8'h1a, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'h63, 8'h64, 8'h65,
        8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
        8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3,
        8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5,
        8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
        8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9,
        8'hda, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf2,
        8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa};
      fill_table(TBL_DC_LUMA, dcl_n, dcl_v);
      fill_table(TBL_DC_CHROMA, dcc_n, dcc_v);
      fill_table(TBL_AC_LUMA, acl_n, acl_v);
      fill_table(TBL_AC_CHROMA, acc_n, acc_v);
      clear();
      errors = 0;
    endfunction

    // Canonical code assignment: codes count up within one length and
    // double when moving to the next length.
    function void fill_table(int t, byte unsigned counts[$], byte unsigned syms[$]);
      int code;
      int idx;
      code = 0;
      idx  = 0;
      for (int i = 0; i < 256; i++) begin
        rom_code[t][i] = 0;
        rom_len[t][i]  = 0;
      end
      for (int k = 1; k <= 16; k++) begin
        for (int i = 0; i < counts[k-1]; i++) begin
          if (idx < syms.size()) begin
            rom_code[t][syms[idx]] = code;
            rom_len[t][syms[idx]]  = k;
          end
          code++;
          idx++;
        end
        code = code << 1;
      end
    endfunction

    function void clear();
      blk_pos  = 0;
      blk_comp = 0;
      dc_last  = '{0, 0, 0};
      zeros    = 0;
      acc      = 0;
      acc_bits = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void emit(int unsigned b);
      coded_byte_t e;
      e.value = b[7:0];
      e.last  = 1'b0;
      expected_bytes.push_back(e);
      if (b[7:0] == jbec_pkg::STUFF_BYTE) begin
        e.value = 8'h00;
        expected_bytes.push_back(e);
      end
    endfunction

    function void append_bits(int unsigned code, int len);
      if (len == 0) return;
      acc = (acc << len) | (code & ((32'd1 << len) - 1));
      acc_bits += len;
      while (acc_bits >= 8) begin
        acc_bits -= 8;
        emit((acc >> acc_bits) & 8'hFF);
        acc &= (32'd1 << acc_bits) - 1;
      end
    endfunction

    function int magnitude_class(int v);
      int m;
      int n;
      m = (v < 0) ? -v : v;
      n = 0;
      while (m != 0) begin
        n++;
        m = m >> 1;
      end
      return n;
    endfunction

    function void append_symbol(int t, logic [7:0] s);
      append_bits(rom_code[t][s], rom_len[t][s]);
    endfunction

    // Negative values are sent as v - 1 truncated to the class width.
    function void append_value(int v, int cls);
      append_bits((v > 0) ? v : v - 1, cls);
    endfunction

    function void note_beat(logic k, logic [1:0] comp, logic [10:0] raw);
      int coef;
      int diff;
      int cls;
      int t;
      int first;
      coef  = $signed(raw);
      first = expected_bytes.size();
      if (k == KIND_FLUSH) begin
        if (acc_bits > 0) begin
          emit(((acc << (8 - acc_bits)) | ((32'd1 << (8 - acc_bits)) - 1)) & 8'hFF);
        end
        clear_keep_comp();
      end else if (blk_pos == 0) begin
        blk_comp = (comp > 2) ? 2 : comp;
        diff = coef - dc_last[blk_comp];
        dc_last[blk_comp] = coef;
        cls = magnitude_class(diff);
        append_symbol((blk_comp == 0) ? TBL_DC_LUMA : TBL_DC_CHROMA, cls[7:0]);
        append_value(diff, cls);
        zeros   = 0;
        blk_pos = 1;
      end else begin
        t = (blk_comp == 0) ? TBL_AC_LUMA : TBL_AC_CHROMA;
        if (coef == 0) begin
          zeros = (zeros + 1) & 63;
          if (blk_pos == jbec_pkg::LAST_POS) append_symbol(t, jbec_pkg::EOB_SYM);
        end else begin
          if (coef == -1024) coef = -1023;
          while (zeros >= 16) begin
            append_symbol(t, jbec_pkg::ZRL_SYM);
            zeros -= 16;
          end
          cls = magnitude_class(coef);
          append_symbol(t, {zeros[3:0], cls[3:0]});
          append_value(coef, cls);
          zeros = 0;
        end
        if (blk_pos >= jbec_pkg::LAST_POS) begin
          blk_pos = 0;
          zeros   = 0;
        end else begin
          blk_pos++;
        end
      end
      if (expected_bytes.size() > first) expected_bytes[$].last = 1'b1;
    endfunction

    // A flush keeps the latched component; it is retaken at position 0.
    function void clear_keep_comp();
      blk_pos  = 0;
      dc_last  = '{0, 0, 0};
      zeros    = 0;
      acc      = 0;
      acc_bits = 0;
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      coded_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %02h (last_of_run %0b)", value, last);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (value !== e.value) begin
        $error("out_byte: expected %02h, got %02h", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [1:0]  component;
  logic [10:0] coefficient;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last_of_run;

  stream_predictor pred = new();

  // Switches shared by the sender and the receiver. send_gaps and
  // recv_gaps enable the random bursts of idle cycles; hold_off asks the
  // receiver for one long stall.
  bit send_gaps;
  bit recv_gaps;
  bit hold_off;

  jpeg_baseline_entropy_coder i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .component   (component),
    .coefficient (coefficient),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Both channels are observed at the rising edge, where the values seen
  // are the ones from before the edge, so the order of events inside one
  // time step cannot matter.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) pred.note_beat(kind, component, coefficient);
    if (!rst && out_valid && !out_stall) pred.check_byte(out_byte, last_of_run);
  end

  // Receiver. It stalls in short random bursts while recv_gaps is set, and
  // once holds off for a long stretch so that the coder's queue fills and
  // the stall reaches back into the input channel.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one beat and returns at the edge where it is taken. Valid stays
  // high into the next beat unless an idle burst is drawn.
  task automatic send_beat(logic k, logic [1:0] comp, logic [10:0] coef);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    component   <= comp;
    coefficient <= coef;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits at clock edges until every predicted byte has been checked.
  task automatic wait_drained();
    while (pred.pending() != 0) @(posedge clk);
  endtask

  // A flush carries random component and coefficient bits; both are ignored.
  task automatic send_flush();
    send_beat(KIND_FLUSH, 2'($urandom_range(0, 3)), 11'($urandom));
  endtask

  // A nonzero value of a random magnitude class; the top class also yields
  // -1024 now and then.
  function automatic logic [10:0] nonzero_value();
    int cls;
    int mag;
    cls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : $urandom_range(1, 5);
    mag = $urandom_range(1 << (cls - 1), (1 << cls) - 1);
    if (cls == 11 && $urandom_range(0, 7) == 0) return 11'h400;
    return ($urandom_range(0, 1) != 0) ? 11'(-mag) : 11'(mag);
  endfunction

  // Sends one block. density is the percentage of nonzero AC values;
  // a stop before 64 ends the block early with a flush.
  task automatic send_block(logic [1:0] comp, int density, int stop);
    logic [10:0] coef;
    send_beat(KIND_COEF, comp, 11'($urandom));
    for (int p = 1; p < 64 && p < stop; p++) begin
      if ($urandom_range(0, 99) < density) coef = nonzero_value();
      else coef = '0;
      if (p == 63 && $urandom_range(0, 3) == 0) coef = nonzero_value();
      send_beat(KIND_COEF, 2'($urandom_range(0, 3)), coef);
    end
    if (stop < 64) send_flush();
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    kind        <= KIND_COEF;
    component   <= '0;
    coefficient <= '0;
    send_gaps   = 1'b0;
    recv_gaps   = 1'b0;
    hold_off    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A flush with no pending bits must give no byte; then
    // DC extremes on component zero and on component three, which acts as Cr,
    // the AC extremes with -1024 saturating, a zero run of more than 16 that
    // needs a run-16 code before its value, and a flush that pads pending bits.
    send_flush();
    send_beat(KIND_COEF, 2'd0, 11'h3FF);
    send_beat(KIND_COEF, 2'd0, 11'h400);
    send_beat(KIND_COEF, 2'd0, 11'h3FF);
    for (int i = 0; i < 18; i++) send_beat(KIND_COEF, 2'd0, 11'd0);
    send_beat(KIND_COEF, 2'd0, 11'h001);
    send_flush();
    send_beat(KIND_COEF, 2'd3, 11'h400);
    send_beat(KIND_COEF, 2'd1, 11'h7FF);
    send_flush();

    // A luma block of 62 zeros and a nonzero last coefficient, so that no
    // end-of-block follows, then a sparse chroma block that ends in end-of-block unless its last value is nonzero.
    for (int p = 0; p < 64; p++)
      send_beat(KIND_COEF, 2'd0, (p == 63) ? 11'h2AA : (p == 0 ? 11'h155 : 11'd0));
    send_block(2'd1, 10, 64);

    // Random part with idle bursts on both sides.
    send_gaps = 1'b1;
    recv_gaps = 1'b1;

    // The receiver holds off while the sender keeps offering a dense block.
    hold_off = 1'b1;
    send_block(2'd0, 90, 64);

    // The sender pauses until every predicted byte has left the coder.
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // Broken sequences: blocks cut short by a flush.
    send_block(2'($urandom_range(0, 3)), 40, $urandom_range(1, 63));
    send_block(2'($urandom_range(0, 3)), 50, $urandom_range(1, 63));

    // The last part runs without any idling.
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_block(2'($urandom_range(0, 3)), 25, 64);
    send_flush();
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("** jpeg_baseline_entropy_coder: PASSED **");
    end else begin
      $display("** jpeg_baseline_entropy_coder: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("** jpeg_baseline_entropy_coder: FAILED **");
    $finish;
  end

endmodule
